// ----- sv/lru_key_value_cache_assert.svh -----
// Assertion macros used by the LRU key/value cache top level.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LKV_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lkv assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define LKV_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("lkv assertion failed");

`endif

// ----- sv/lkv_pkg.sv -----
// Types shared by the LRU key/value cache cells and top level.
// No dependencies.
package lkv_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CapWidth   = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef struct packed {
    logic [KeyWidth-1:0]   key;
    logic [ValueWidth-1:0] value;
  } entry_t;

  typedef struct packed {
    logic valid;  // cell lies inside the filled region
    logic shift;  // take the neighbor's entry this cycle
  } cell_ctrl_t;

endpackage

// ----- sv/lru_key_value_cache.sv -----
// Top level of the LRU key/value cache: a move-to-front chain of lkv_cell.
// Depends on lkv_pkg, lkv_cell and lru_key_value_cache_assert.svh.
//
//   channel | direction | handshake                  | word
//   cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_data_i (capacity)
//   in      | in        | in_valid_i / in_ready_o    | opcode_i, key_i, write_value_i
//   out     | out       | out_valid_o / out_ready_i  | hit_o, read_value_o
//
// One word per cycle: the key compare across all cells, the hit encode and
// the chain shift complete in the accepting cycle; the result register
// shows the answer in the next cycle. Cell 0 is most recent, the last filled
// cell is least recent. Reset sets capacity 16 and empties the chain; a
// capacity write empties it as well. A stalled result holds the input off
// only while the result register is still full.
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lkv_pkg::CapWidth-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [lkv_pkg::KeyWidth-1:0]      key_i,
  input  logic [lkv_pkg::ValueWidth-1:0]    write_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [lkv_pkg::ValueWidth-1:0]    read_value_o
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [lkv_pkg::CapWidth-1:0]   capacity_q;
  logic [CW-1:0]                  count_q, count_d;
  logic                           out_valid_q;
  logic                           hit_q;
  logic [lkv_pkg::ValueWidth-1:0] read_value_q;

  logic                           in_fire;
  logic [CW-1:0]                  cap_eff;
  logic                           full;
  logic [MAX_ENTRIES-1:0]         hit_vec;
  logic                           any_hit;
  logic [IW-1:0]                  hit_idx;
  logic [lkv_pkg::ValueWidth-1:0] hit_value;
  logic [IW-1:0]                  shift_limit;
  logic                           upd;
  lkv_pkg::entry_t                new_entry;
  lkv_pkg::entry_t                chain [MAX_ENTRIES];
  lkv_pkg::cell_ctrl_t            ctrl  [MAX_ENTRIES];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  assign cap_eff = (32'(capacity_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(capacity_q);
  assign full    = (count_q >= cap_eff);

  // Keys in the filled region are distinct, so at most one cell hits.
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx   = hit_idx | IW'(i);
        hit_value = hit_value | chain[i].value;
      end
    end
  end
  assign any_hit = |hit_vec;

  always_comb begin
    if (any_hit) begin
      shift_limit = hit_idx;
    end else if (full) begin
      shift_limit = IW'(cap_eff - CW'(1));  // drop the least recent entry
    end else begin
      shift_limit = IW'(count_q);
    end
  end

  assign upd = in_fire && (any_hit || (opcode_i == lkv_pkg::OpPut && cap_eff != '0));

  assign new_entry.key   = key_i;
  assign new_entry.value = (opcode_i == lkv_pkg::OpPut) ? write_value_i : hit_value;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    assign ctrl[g].valid = (CW'(g) < count_q);
    assign ctrl[g].shift = upd && (IW'(g) <= shift_limit);
    lkv_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .key_i   (key_i),
      .entry_i ((g == 0) ? new_entry : chain[(g == 0) ? 0 : g - 1]),
      .entry_o (chain[g]),
      .hit_o   (hit_vec[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cfg_valid_i) begin
      count_d = '0;
    end else if (upd && !any_hit && !full) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= lkv_pkg::CapReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hit_q        <= any_hit;
      read_value_q <= (any_hit && opcode_i == lkv_pkg::OpGet) ? hit_value : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = read_value_q;

  `LKV_ASSERT(a_single_hit, $onehot0(hit_vec))
  `LKV_ASSERT(a_count_in_range, count_q <= cap_eff || count_q == '0)
  `LKV_ASSERT_NEXT(a_result_follows, in_fire, out_valid_q)
  `LKV_ASSERT_NEXT(a_put_reads_zero, in_fire && opcode_i == lkv_pkg::OpPut, read_value_q == '0)

endmodule

// ----- sv/lkv_cell.sv -----
// One cell of the recency-ordered chain: holds one key/value entry.
// Depends on lkv_pkg for the entry and control types.
module lkv_cell (
  input  logic                               clk_i,
  input  lkv_pkg::cell_ctrl_t                ctrl_i,
  input  logic [lkv_pkg::KeyWidth-1:0]       key_i,
  input  lkv_pkg::entry_t                    entry_i,
  output lkv_pkg::entry_t                    entry_o,
  output logic                               hit_o
);

  lkv_pkg::entry_t entry_q;

  // Advance the neighbor's entry one step toward the old end.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = ctrl_i.valid && (entry_q.key == key_i);

endmodule
